@@ rtl/pmuio_pkg.sv @@
// Shared types, constants and trap window tables for the PMU I/O trap monitor.
// No dependencies; used by pmuio_trap, pmuio_regs and pmu_io_trap_monitor in rtl.
package pmuio_pkg;

	localparam int NUM_TRAPS = 22;
	localparam int REG_N     = 68;          // stored bytes 0x40..0x83
	localparam logic [7:0] REG_LO = 8'h40;

	// input modes
	localparam logic [1:0] MODE_WR = 2'd0;
	localparam logic [1:0] MODE_RD = 2'd1;
	localparam logic [1:0] MODE_IO = 2'd2;

	// configuration register indexes
	localparam logic CFG_GATE = 1'b0;
	localparam logic CFG_LATE = 1'b1;

	// window kinds
	localparam logic [1:0] KIND_PLAIN = 2'd0;
	localparam logic [1:0] KIND_IDE   = 2'd1;
	localparam logic [1:0] KIND_MASK  = 2'd2;
	localparam logic [1:0] KIND_BM    = 2'd3;

	typedef logic [REG_N-1:0][7:0] reg_vec_t;

	typedef struct packed {
		logic [3:0][7:0] set;   // bits to set in 0x64..0x67
		logic            ev;
		logic            irq;
	} trap_res_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] address;
		logic [7:0]  data;
		logic [3:0]  drive_selected;
	} item_t;

	localparam logic [1:0] WIN_KIND [NUM_TRAPS] = '{
		KIND_BM, KIND_BM, KIND_IDE, KIND_IDE,
		KIND_PLAIN, KIND_PLAIN, KIND_PLAIN, KIND_PLAIN, KIND_PLAIN, KIND_PLAIN,
		KIND_MASK, KIND_MASK,
		KIND_PLAIN, KIND_PLAIN, KIND_PLAIN, KIND_PLAIN, KIND_PLAIN, KIND_PLAIN,
		KIND_PLAIN, KIND_PLAIN, KIND_IDE, KIND_IDE};

	// status byte of each window, as offset from 0x64
	localparam logic [1:0] WIN_SREG [NUM_TRAPS] = '{
		2'd0, 2'd0, 2'd3, 2'd3,
		2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
		2'd0, 2'd0, 2'd0, 2'd0};

	localparam logic [7:0] WIN_SBIT [NUM_TRAPS] = '{
		8'h00, 8'h00, 8'h02, 8'h01,
		8'h80, 8'h80, 8'h40, 8'h20, 8'h10, 8'h10, 8'h04, 8'h02,
		8'h40, 8'h10, 8'h08, 8'h04, 8'h02, 8'h02,
		8'h20, 8'h20, 8'h10, 8'h08};

	localparam logic [1:0] WIN_DRIVE [NUM_TRAPS] = '{
		2'd0, 2'd0, 2'd0, 2'd2,
		2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
		2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
		2'd0, 2'd0, 2'd1, 2'd3};

	localparam logic [15:0] WIN_BASE [NUM_TRAPS] = '{
		16'h0000, 16'h0000, 16'h01f0, 16'h0170,
		16'h0064, 16'h0060, 16'h03f8, 16'h02f8, 16'h0378, 16'h0278,
		16'h0000, 16'h0000,
		16'h03b0, 16'h0000, 16'h0000, 16'h0000, 16'h0200, 16'h0388,
		16'h03f0, 16'h0370, 16'h01f0, 16'h0170};

	localparam logic [8:0] WIN_SIZE [NUM_TRAPS] = '{
		9'h008, 9'h008, 9'h008, 9'h008,
		9'h001, 9'h001, 9'h008, 9'h008, 9'h008, 9'h008,
		9'h040, 9'h100,
		9'h030, 9'h008, 9'h014, 9'h004, 9'h008, 9'h004,
		9'h008, 9'h008, 9'h008, 9'h008};

	localparam logic [15:0] SEL13 [4] = '{16'h0f40, 16'h0e80, 16'h0604, 16'h0530};
	localparam logic [15:0] SEL14 [4] = '{16'h0280, 16'h0260, 16'h0240, 16'h0220};
	localparam logic [15:0] SEL15 [4] = '{16'h0330, 16'h0320, 16'h0310, 16'h0300};

endpackage

@@ rtl/pmuio_in_if.sv @@
// Input item channel: valid/ready handshake plus access fields.
// Depends on nothing.
interface pmuio_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [15:0] address;
	logic [7:0]  data;
	logic [3:0]  drive_selected;

	modport source (output valid, mode, address, data, drive_selected, input ready);
	modport sink   (input valid, mode, address, data, drive_selected, output ready);
endinterface

@@ rtl/pmuio_out_if.sv @@
// Result item channel: valid/ready handshake plus result fields.
// Depends on nothing.
interface pmuio_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       pmu_event;
	logic       irq_update;

	modport source (output valid, read_data, pmu_event, irq_update, input ready);
	modport sink   (input valid, read_data, pmu_event, irq_update, output ready);
endinterface

@@ rtl/pmuio_trap.sv @@
// Parallel compare of one I/O access against all trap windows.
// Depends on pmuio_pkg.
module pmuio_trap (
	input  pmuio_pkg::reg_vec_t  regs,
	input  logic [15:0]          address,
	input  logic [3:0]           drive_selected,
	input  logic                 late,
	output pmuio_pkg::trap_res_t res
);
	logic [15:0] base [pmuio_pkg::NUM_TRAPS];
	logic [8:0]  size [pmuio_pkg::NUM_TRAPS];
	logic [7:0]  mask [pmuio_pkg::NUM_TRAPS];
	logic        on   [pmuio_pkg::NUM_TRAPS];
	logic [pmuio_pkg::NUM_TRAPS-1:0] hit;

	// build the window set from current register contents
	always_comb begin
		logic [15:0] bm;
		logic [6:0]  si;
		for (int i = 0; i < pmuio_pkg::NUM_TRAPS; i++) begin
			si = 7'h20 + {5'd0, pmuio_pkg::WIN_SREG[i]};
			base[i] = pmuio_pkg::WIN_BASE[i];
			size[i] = pmuio_pkg::WIN_SIZE[i];
			mask[i] = 8'hff;
			on[i]   = ((regs[si] | regs[si + 7'h20]) & pmuio_pkg::WIN_SBIT[i]) != 8'h00;
		end
		bm = {regs[7'h3f], regs[7'h3e]} & 16'hffe0;
		base[0] = bm;
		base[1] = bm + 16'd8;
		on[0]   = regs[7'h3e][3];
		on[1]   = regs[7'h3e][2];
		base[10] = {regs[7'h1d], regs[7'h1c]} & 16'h03ff;
		mask[10] = {2'b00, regs[7'h1d][7:2]};
		base[11] = {regs[7'h1f], regs[7'h1e]};
		mask[11] = late ? (regs[7'h0d] & 8'h1f) : regs[7'h0d];
		size[11] = late ? 9'h020 : 9'h100;
		base[13] = pmuio_pkg::SEL13[regs[7'h0c][7:6]];
		base[14] = pmuio_pkg::SEL14[regs[7'h0c][5:4]];
		base[15] = pmuio_pkg::SEL15[regs[7'h0c][3:2]];
	end

	// match each window
	always_comb begin
		logic [16:0] a;
		logic [16:0] top;
		a = {1'b0, address};
		for (int i = 0; i < pmuio_pkg::NUM_TRAPS; i++) begin
			top = {1'b0, base[i]} + {8'd0, size[i]};
			hit[i] = on[i] && (a >= {1'b0, base[i]}) && (a < top);
			if (pmuio_pkg::WIN_KIND[i] == pmuio_pkg::KIND_IDE)
				hit[i] = hit[i] && drive_selected[pmuio_pkg::WIN_DRIVE[i]];
			if (pmuio_pkg::WIN_KIND[i] == pmuio_pkg::KIND_MASK)
				hit[i] = hit[i] && ((address[7:0] & mask[i]) == (base[i][7:0] & mask[i]));
		end
	end

	// merge effects of all hits
	always_comb begin
		logic [6:0] si;
		res = '0;
		for (int i = 0; i < pmuio_pkg::NUM_TRAPS; i++) begin
			si = 7'h20 + {5'd0, pmuio_pkg::WIN_SREG[i]};
			if (hit[i]) begin
				if (pmuio_pkg::WIN_KIND[i] == pmuio_pkg::KIND_BM) begin
					res.set[3] = res.set[3] | 8'h02;
					res.set[0] = res.set[0] | 8'h10;
					res.ev     = 1'b1;
				end else begin
					res.set[pmuio_pkg::WIN_SREG[i]] =
						res.set[pmuio_pkg::WIN_SREG[i]] | pmuio_pkg::WIN_SBIT[i];
					if ((regs[si] & pmuio_pkg::WIN_SBIT[i]) != 8'h00)
						res.ev = 1'b1;
					if ((regs[si + 7'h20] & pmuio_pkg::WIN_SBIT[i]) != 8'h00)
						res.irq = 1'b1;
				end
			end
		end
	end
endmodule

@@ rtl/pmuio_regs.sv @@
// Register file 0x40..0x83 with config write, W1C status and trap status update;
// identity bytes are constants. Depends on pmuio_pkg.
module pmuio_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 upd,
	input  logic                 gate,
	input  pmuio_pkg::item_t     item,
	input  pmuio_pkg::trap_res_t trap,
	output pmuio_pkg::reg_vec_t  regs,
	output logic [7:0]           rd_byte,
	output logic                 wr_event
);
	pmuio_pkg::reg_vec_t regs_q;
	pmuio_pkg::reg_vec_t regs_d;
	logic [7:0] off;
	logic [7:0] idx8;
	logic [6:0] idx;

	assign off  = item.address[7:0];
	assign idx8 = off - pmuio_pkg::REG_LO;
	assign idx  = idx8[6:0];
	assign regs = regs_q;

	// next register state for the item in flight
	always_comb begin
		regs_d   = regs_q;
		wr_event = 1'b0;
		if (item.mode == pmuio_pkg::MODE_WR && gate) begin
			if (off >= 8'h64 && off <= 8'h67) begin
				regs_d[idx] = regs_q[idx] & ~item.data;
			end else if (off == 8'h7c) begin
				regs_d[idx] = item.data;
				if (item.data[1]) begin
					regs_d[7'h24] = regs_q[7'h24] | 8'h04;
					wr_event = regs_q[7'h20][2];
				end
			end else if ((off >= 8'h40 && off <= 8'h4d) || (off >= 8'h50 && off <= 8'h63) ||
					(off >= 8'h68 && off <= 8'h7b) || (off >= 8'h7d && off <= 8'h83)) begin
				regs_d[idx] = item.data;
			end
		end else if (item.mode == pmuio_pkg::MODE_IO) begin
			for (int s = 0; s < 4; s++)
				regs_d[7'h24 + 7'(s)] = regs_q[7'h24 + 7'(s)] | trap.set[s];
		end
	end

	// read byte: identity constants, stored bytes, zero elsewhere
	always_comb begin
		case (off)
			8'h00: rd_byte = 8'h39;
			8'h01: rd_byte = 8'h10;
			8'h02: rd_byte = 8'h09;
			8'h07: rd_byte = 8'h02;
			8'h0b: rd_byte = 8'hff;
			8'h0e: rd_byte = 8'h80;
			default: rd_byte = (off >= 8'h40 && off <= 8'h83) ? regs_q[idx] : 8'h00;
		endcase
	end

	// commit when the item advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (upd) begin
			regs_q <= regs_d;
		end
	end
endmodule

@@ rtl/pmu_io_trap_monitor.sv @@
// Top level of the PMU I/O trap monitor: input register, register file, trap
// compare and result register. Depends on pmuio_pkg, pmuio_in_if, pmuio_out_if,
// pmuio_regs and pmuio_trap.
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   mode, address, data, drive_selected
//  out_ch   out  valid/ready   read_data, pmu_event, irq_update
//  cfg      in   cfg_we        cfg_index, cfg_wdata
//
// An item is registered on acceptance, its result in the output register as it
// advances; one item per cycle while the output does not stall. State updates
// commit as it advances, so the next item sees them. A stalled output holds
// the input register; reset sets gate and clears late, valids and regs_q.
module pmu_io_trap_monitor (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic             cfg_wdata,
	pmuio_in_if.sink         in_ch,
	pmuio_out_if.source      out_ch
);
	pmuio_pkg::item_t     item_s1;
	logic                 valid_s1;
	logic                 gate_q;
	logic                 late_q;
	logic                 adv;
	pmuio_pkg::reg_vec_t  regs;
	pmuio_pkg::trap_res_t trap;
	logic [7:0]           rd_byte;
	logic                 wr_event;
	logic                 out_valid_q;
	logic [7:0]           rdata_q;
	logic                 ev_q;
	logic                 irq_q;

	assign adv         = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q <= 1'b1;
			late_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				pmuio_pkg::CFG_GATE: gate_q <= cfg_wdata;
				pmuio_pkg::CFG_LATE: late_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.mode           <= in_ch.mode;
			item_s1.address        <= in_ch.address;
			item_s1.data           <= in_ch.data;
			item_s1.drive_selected <= in_ch.drive_selected;
		end
	end

	pmuio_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (adv),
		.gate     (gate_q),
		.item     (item_s1),
		.trap     (trap),
		.regs     (regs),
		.rd_byte  (rd_byte),
		.wr_event (wr_event)
	);

	pmuio_trap u_trap (
		.regs           (regs),
		.address        (item_s1.address),
		.drive_selected (item_s1.drive_selected),
		.late           (late_q),
		.res            (trap)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rdata_q <= (item_s1.mode == pmuio_pkg::MODE_RD) ? rd_byte : 8'h00;
			ev_q    <= (item_s1.mode == pmuio_pkg::MODE_IO) ? trap.ev : wr_event;
			irq_q   <= (item_s1.mode == pmuio_pkg::MODE_IO) && trap.irq;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.read_data  = rdata_q;
	assign out_ch.pmu_event  = ev_q;
	assign out_ch.irq_update = irq_q;

	// an advancing item always yields a result
	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("result lost after advance");

	// a stalled item stays in the input register
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("input register dropped a stalled item");

	// the input register advances only into a free or draining output
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> !out_valid_q || out_ch.ready)
		else $error("output register overrun");
endmodule

@@ sim/pmu_io_trap_monitor_tb.sv @@
// Self-checking testbench for the PMU I/O trap monitor: directed table, then
// random accesses checked against a behavioral predictor of the register file.
// Depends on pmuio_pkg, pmuio_in_if, pmuio_out_if and pmu_io_trap_monitor.
`timescale 1ns / 100ps

module pmu_io_trap_monitor_tb;

	localparam logic [1:0] MODE_RSVD = 2'd3;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RAND_PER_PHASE = 200;

	typedef struct {
		logic [7:0] read_data;
		logic       pmu_event;
		logic       irq_update;
	} result_t;

	typedef struct {
		logic [1:0]  mode;
		logic [15:0] address;
		logic [7:0]  data;
		logic [3:0]  drives;
		bit          pinned;
		result_t     res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic cfg_wdata = 1'b0;

	pmuio_in_if  in_ch ();
	pmuio_out_if out_ch ();

	pmu_io_trap_monitor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// shadow of the block state
	logic [7:0] regs [256];
	bit         gate_on;
	bit         late_on;
	bit         hit_ev;
	bit         hit_irq;

	result_t pending_q [$];
	bit      pinned_q [$];
	result_t pinned_res_q [$];
	row_t    dir_rows [$];
	int      errors = 0;
	int      idle_cycles = 0;
	int      stall_left = 0;
	bit      calm = 1'b0;

	localparam logic [15:0] SEL_A [4] = '{16'h0f40, 16'h0e80, 16'h0604, 16'h0530};
	localparam logic [15:0] SEL_B [4] = '{16'h0280, 16'h0260, 16'h0240, 16'h0220};
	localparam logic [15:0] SEL_C [4] = '{16'h0330, 16'h0320, 16'h0310, 16'h0300};
	localparam logic [15:0] PORTS [25] = '{
		16'h01f0, 16'h0170, 16'h0064, 16'h0060, 16'h03f8, 16'h02f8, 16'h0378,
		16'h0278, 16'h03b0, 16'h0f40, 16'h0e80, 16'h0604, 16'h0530, 16'h0280,
		16'h0260, 16'h0240, 16'h0220, 16'h0330, 16'h0320, 16'h0310, 16'h0300,
		16'h0200, 16'h0388, 16'h03f0, 16'h0370};

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void reset_shadow();
		foreach (regs[i]) regs[i] = 8'h00;
		regs[8'h00] = 8'h39;
		regs[8'h01] = 8'h10;
		regs[8'h02] = 8'h09;
		regs[8'h07] = 8'h02;
		regs[8'h0b] = 8'hff;
		regs[8'h0e] = 8'h80;
		gate_on = 1'b1;
		late_on = 1'b0;
	endfunction

	function automatic bit in_window(logic [15:0] port, logic [15:0] base, int size);
		return (int'(port) >= int'(base)) && (int'(port) < int'(base) + size);
	endfunction

	// set the status bit of a hit window and collect its effects
	function automatic void mark_hit(logic [7:0] sreg, logic [7:0] sbit);
		regs[sreg + 8'h04] |= sbit;
		if ((regs[sreg] & sbit) != 0) hit_ev = 1'b1;
		if ((regs[sreg + 8'h20] & sbit) != 0) hit_irq = 1'b1;
	endfunction

	function automatic bit is_stored(logic [7:0] off);
		return (off >= 8'h40 && off <= 8'h4d) || (off >= 8'h50 && off <= 8'h63) ||
		       (off >= 8'h68 && off <= 8'h7b) || (off >= 8'h7d && off <= 8'h83);
	endfunction

	function automatic result_t trap_access(logic [1:0] mode, logic [15:0] port,
	                                        logic [7:0] data, logic [3:0] drv);
		result_t    res;
		logic [7:0] off;
		logic [7:0] on0, on1, on2, on3, mk;
		logic [15:0] bm_base, b10, b11;
		bit         bm_hit;
		off = port[7:0];
		res = '{8'h00, 1'b0, 1'b0};
		hit_ev = 1'b0;
		hit_irq = 1'b0;
		bm_hit = 1'b0;
		case (mode)
			pmuio_pkg::MODE_WR: begin
				if (gate_on) begin
					if (off >= 8'h64 && off <= 8'h67) begin
						regs[off] &= ~data;
					end else if (off == 8'h7c) begin
						regs[off] = data;
						if (data[1]) begin
							regs[8'h64] |= 8'h04;
							if (regs[8'h60][2]) hit_ev = 1'b1;
						end
					end else if (is_stored(off)) begin
						regs[off] = data;
					end
				end
			end
			pmuio_pkg::MODE_RD: res.read_data = regs[off];
			pmuio_pkg::MODE_IO: begin
				// enables come from the state before this access
				on0 = regs[8'h60] | regs[8'h80];
				on1 = regs[8'h61] | regs[8'h81];
				on2 = regs[8'h62] | regs[8'h82];
				on3 = regs[8'h63] | regs[8'h83];
				bm_base = {regs[8'h7f], regs[8'h7e]} & 16'hffe0;
				if (regs[8'h7e][3] && in_window(port, bm_base, 8)) bm_hit = 1'b1;
				if (regs[8'h7e][2] && in_window(port, bm_base + 16'd8, 8)) bm_hit = 1'b1;
				if (bm_hit) begin
					regs[8'h67] |= 8'h02;
					regs[8'h64] |= 8'h10;
					hit_ev = 1'b1;
				end
				// drive-qualified IDE ranges
				if (on3[1] && drv[0] && in_window(port, 16'h01f0, 8)) mark_hit(8'h63, 8'h02);
				if (on3[0] && drv[2] && in_window(port, 16'h0170, 8)) mark_hit(8'h63, 8'h01);
				if (on0[4] && drv[1] && in_window(port, 16'h01f0, 8)) mark_hit(8'h60, 8'h10);
				if (on0[3] && drv[3] && in_window(port, 16'h0170, 8)) mark_hit(8'h60, 8'h08);
				// fixed legacy ranges
				if (on2[7] && (in_window(port, 16'h0064, 1) || in_window(port, 16'h0060, 1)))
					mark_hit(8'h62, 8'h80);
				if (on2[6] && in_window(port, 16'h03f8, 8)) mark_hit(8'h62, 8'h40);
				if (on2[5] && in_window(port, 16'h02f8, 8)) mark_hit(8'h62, 8'h20);
				if (on2[4] && (in_window(port, 16'h0378, 8) || in_window(port, 16'h0278, 8)))
					mark_hit(8'h62, 8'h10);
				// programmable masked ranges
				b10 = {regs[8'h5d], regs[8'h5c]} & 16'h03ff;
				mk = regs[8'h5d] >> 2;
				if (on2[2] && in_window(port, b10, 64) && ((port[7:0] & mk) == (b10[7:0] & mk)))
					mark_hit(8'h62, 8'h04);
				b11 = {regs[8'h5f], regs[8'h5e]};
				mk = late_on ? (regs[8'h4d] & 8'h1f) : regs[8'h4d];
				if (on2[1] && in_window(port, b11, late_on ? 32 : 256) &&
				    ((port[7:0] & mk) == (b11[7:0] & mk)))
					mark_hit(8'h62, 8'h02);
				// ranges selected through 0x4c and the remaining fixed ranges
				if (on1[6] && in_window(port, 16'h03b0, 48)) mark_hit(8'h61, 8'h40);
				if (on1[4] && in_window(port, SEL_A[regs[8'h4c][7:6]], 8)) mark_hit(8'h61, 8'h10);
				if (on1[3] && in_window(port, SEL_B[regs[8'h4c][5:4]], 20)) mark_hit(8'h61, 8'h08);
				if (on1[2] && in_window(port, SEL_C[regs[8'h4c][3:2]], 4)) mark_hit(8'h61, 8'h04);
				if (on1[1] && (in_window(port, 16'h0200, 8) || in_window(port, 16'h0388, 4)))
					mark_hit(8'h61, 8'h02);
				if (on0[5] && (in_window(port, 16'h03f0, 8) || in_window(port, 16'h0370, 8)))
					mark_hit(8'h60, 8'h20);
			end
			default: ;
		endcase
		res.pmu_event = hit_ev;
		res.irq_update = hit_irq;
		return res;
	endfunction

	// receiver: random stalls, mostly short, some long
	always @(negedge clk) begin
		if (calm || !arst_n) begin
			out_ch.ready <= arst_n;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 80) begin
			out_ch.ready <= 1'b1;
		end else begin
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
			out_ch.ready <= 1'b0;
		end
	end

	// check results, then predict newly accepted items
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.read_data, out_ch.pmu_event, out_ch.irq_update};
				if (pending_q.size() == 0) begin
					$error("unexpected result item rd=%h ev=%b irq=%b",
					       got.read_data, got.pmu_event, got.irq_update);
					errors++;
				end else begin
					want = pending_q.pop_front();
					if (got.read_data !== want.read_data) begin
						$error("read_data expected %h actual %h", want.read_data, got.read_data);
						errors++;
					end
					if (got.pmu_event !== want.pmu_event) begin
						$error("pmu_event expected %b actual %b", want.pmu_event, got.pmu_event);
						errors++;
					end
					if (got.irq_update !== want.irq_update) begin
						$error("irq_update expected %b actual %b", want.irq_update, got.irq_update);
						errors++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				want = trap_access(in_ch.mode, in_ch.address, in_ch.data, in_ch.drive_selected);
				if (pinned_q.pop_front()) want = pinned_res_q.pop_front();
				else void'(pinned_res_q.pop_front());
				pending_q.push_back(want);
			end
			// watchdog on handshake progress
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// send one item; called and returning at a falling edge
	task automatic send_access(logic [1:0] mode, logic [15:0] port, logic [7:0] data,
	                           logic [3:0] drv, bit pinned, result_t res);
		int gap;
		pinned_q.push_back(pinned);
		pinned_res_q.push_back(res);
		in_ch.valid <= 1'b1;
		in_ch.mode <= mode;
		in_ch.address <= port;
		in_ch.data <= data;
		in_ch.drive_selected <= drv;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		if (calm) gap = 0;
		else if ($urandom_range(0, 99) < 65) gap = 0;
		else if ($urandom_range(0, 9) != 0) gap = $urandom_range(1, 3);
		else gap = $urandom_range(10, 40);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// hold the sender until every result is back
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_cfg(logic idx, logic value);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == pmuio_pkg::CFG_GATE) gate_on = value;
		else late_on = value;
		@(negedge clk);
	endtask

	task automatic add_row(logic [1:0] mode, logic [15:0] port, logic [7:0] data,
	                       logic [3:0] drv, bit pinned, logic [7:0] rd, bit ev, bit irq);
		dir_rows.push_back('{mode, port, data, drv, pinned, '{rd, ev, irq}});
	endtask

	function automatic logic [15:0] pick_port();
		case ($urandom_range(0, 7))
			0, 1: return 16'($urandom_range(0, 16'hffff));
			2: return 16'(({regs[8'h7f], regs[8'h7e]} & 16'hffe0) + $urandom_range(0, 17));
			3: return 16'(({regs[8'h5d], regs[8'h5c]} & 16'h03ff) + $urandom_range(0, 70));
			4: return 16'({regs[8'h5f], regs[8'h5e]} + $urandom_range(0, 260));
			default: return 16'(PORTS[$urandom_range(0, 24)] + $urandom_range(0, 15));
		endcase
	endfunction

	task automatic send_random();
		int         pick;
		logic [1:0] mode;
		logic [15:0] port;
		pick = $urandom_range(0, 99);
		port = 16'($urandom_range(0, 16'hffff));
		if (pick < 30) begin
			mode = pmuio_pkg::MODE_WR;
			if ($urandom_range(0, 9) < 8) port[7:0] = 8'($urandom_range(8'h40, 8'h83));
		end else if (pick < 50) begin
			mode = pmuio_pkg::MODE_RD;
			if ($urandom_range(0, 1) != 0) port[7:0] = 8'($urandom_range(8'h40, 8'h83));
		end else if (pick < 95) begin
			mode = pmuio_pkg::MODE_IO;
			port = pick_port();
		end else begin
			mode = MODE_RSVD;
		end
		send_access(mode, port, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), 1'b0,
		            '{8'h00, 1'b0, 1'b0});
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.mode = pmuio_pkg::MODE_WR;
		in_ch.address = 16'h0000;
		in_ch.data = 8'h00;
		in_ch.drive_selected = 4'h0;
		out_ch.ready = 1'b0;
		reset_shadow();

		// directed table: identity bytes, reserved mode, window extremes
		add_row(pmuio_pkg::MODE_RD, 16'h0000, 8'h00, 4'h0, 1'b1, 8'h39, 1'b0, 1'b0);
		add_row(pmuio_pkg::MODE_RD, 16'hff0b, 8'hff, 4'hf, 1'b1, 8'hff, 1'b0, 1'b0);
		add_row(pmuio_pkg::MODE_RD, 16'h000e, 8'h00, 4'h0, 1'b1, 8'h80, 1'b0, 1'b0);
		add_row(MODE_RSVD,          16'hffff, 8'hff, 4'hf, 1'b1, 8'h00, 1'b0, 1'b0);
		add_row(pmuio_pkg::MODE_WR, 16'h0062, 8'hff, 4'h0, 1'b1, 8'h00, 1'b0, 1'b0);
		add_row(pmuio_pkg::MODE_WR, 16'h0082, 8'hff, 4'h0, 1'b1, 8'h00, 1'b0, 1'b0);
		add_row(pmuio_pkg::MODE_IO, 16'h0064, 8'h00, 4'h0, 1'b1, 8'h00, 1'b1, 1'b1);
		add_row(pmuio_pkg::MODE_IO, 16'h03ff, 8'h00, 4'h0, 1'b1, 8'h00, 1'b1, 1'b1);
		add_row(pmuio_pkg::MODE_IO, 16'hffff, 8'h00, 4'hf, 1'b1, 8'h00, 1'b0, 1'b0);
		add_row(pmuio_pkg::MODE_WR, 16'h007e, 8'h0c, 4'h0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(pmuio_pkg::MODE_WR, 16'h007f, 8'hff, 4'h0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(pmuio_pkg::MODE_IO, 16'hff00, 8'h00, 4'h0, 1'b1, 8'h00, 1'b1, 1'b0);
		add_row(pmuio_pkg::MODE_IO, 16'hff0f, 8'h00, 4'h0, 1'b1, 8'h00, 1'b1, 1'b0);
		add_row(pmuio_pkg::MODE_WR, 16'h0060, 8'h3c, 4'h0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(pmuio_pkg::MODE_WR, 16'h0080, 8'h38, 4'h0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(pmuio_pkg::MODE_WR, 16'h0063, 8'h03, 4'h0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(pmuio_pkg::MODE_IO, 16'h01f0, 8'h00, 4'h0, 1'b1, 8'h00, 1'b0, 1'b0);
		add_row(pmuio_pkg::MODE_IO, 16'h01f7, 8'h00, 4'hf, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(pmuio_pkg::MODE_IO, 16'h0170, 8'h00, 4'h4, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(pmuio_pkg::MODE_WR, 16'h007c, 8'h02, 4'h0, 1'b1, 8'h00, 1'b1, 1'b0);
		add_row(pmuio_pkg::MODE_RD, 16'h0064, 8'h00, 4'h0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(pmuio_pkg::MODE_WR, 16'h0064, 8'hff, 4'h0, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(pmuio_pkg::MODE_RD, 16'h0064, 8'h00, 4'h0, 1'b1, 8'h00, 1'b0, 1'b0);
		add_row(pmuio_pkg::MODE_RD, 16'h0067, 8'h00, 4'h0, 1'b0, 8'h00, 1'b0, 1'b0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		write_cfg(pmuio_pkg::CFG_GATE, 1'b1);
		write_cfg(pmuio_pkg::CFG_LATE, 1'b0);
		foreach (dir_rows[i])
			send_access(dir_rows[i].mode, dir_rows[i].address, dir_rows[i].data,
			            dir_rows[i].drives, dir_rows[i].pinned, dir_rows[i].res);

		// random phases across three of the four gate/variant settings
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: ;
				1: write_cfg(pmuio_pkg::CFG_LATE, 1'b1);
				2: write_cfg(pmuio_pkg::CFG_GATE, 1'b0);
				default: begin
					write_cfg(pmuio_pkg::CFG_GATE, 1'b1);
					write_cfg(pmuio_pkg::CFG_LATE, 1'b0);
				end
			endcase
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				calm = (phase == 1) && (n < RAND_PER_PHASE / 2);
				if (n == RAND_PER_PHASE / 2) drain();
				send_random();
			end
			calm = 1'b0;
		end

		drain();
		repeat (10) @(negedge clk);
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
rtl/pmuio_pkg.sv
rtl/pmuio_in_if.sv
rtl/pmuio_out_if.sv
rtl/pmuio_trap.sv
rtl/pmuio_regs.sv
rtl/pmu_io_trap_monitor.sv
sim/pmu_io_trap_monitor_tb.sv
